// ----- rtl/core/ale_pkg.sv -----
// Shared types and action codes for the array list engine.
// No dependencies; the engine top, the checker and the testbench import this package.
package ale_pkg;

	// Action codes carried in the command transaction.
	localparam logic [2:0] ACT_READ   = 3'd0;
	localparam logic [2:0] ACT_WRITE  = 3'd1;
	localparam logic [2:0] ACT_INSERT = 3'd2;
	localparam logic [2:0] ACT_REMOVE = 3'd3;
	localparam logic [2:0] ACT_SEARCH = 3'd4;
	localparam logic [2:0] ACT_CLEAR  = 3'd5;

	// Command transaction.
	typedef struct packed {
		logic [2:0]  action;
		logic [5:0]  position;
		logic [31:0] item_value;
	} ale_cmd_t;

	// Result transaction.
	typedef struct packed {
		logic        ok;
		logic [31:0] read_value;
		logic        hit;
		logic [5:0]  hit_position;
		logic [6:0]  list_length;
		logic        is_empty;
		logic        is_full;
	} ale_result_t;

endpackage

// ----- rtl/core/array_list_engine_top.sv -----
// Array list engine: ordered list store over one RAM, walked by a small sequencer.
// Depends on ale_pkg and ale_ram.
// A command keeps busy high while its entries are read and the last read data returns;
// done pulses on the edge at which busy falls. Insert and remove walk the entries from
// the position to the end, search walks the whole length, read walks one.
// The RAM's single read and single write port set this pace: one entry per cycle.
// Reset clears the length and the sequencer at once; the receiver cannot stall results.
module array_list_engine_top #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ale_pkg::ale_cmd_t   cmd,
	output logic                done,
	output ale_pkg::ale_result_t result
);
	import ale_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > 7) ? CW : 7;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                state_q;
	logic [2:0]            act_q;
	logic [LW-1:0]         pos_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic                  legal_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         rem_q;
	logic [AW-1:0]         ra_q;
	logic                  pend_q;
	logic [AW-1:0]         pa_q;
	logic [DATA_WIDTH-1:0] rdv_q;
	logic                  hit_q;
	logic [AW-1:0]         hpos_q;
	logic                  done_q;
	ale_result_t           res_q;

	logic                  accept;
	logic [LW-1:0]         cnt_ext;
	logic [LW-1:0]         pos_ext;
	logic [LW-1:0]         cap_ext;
	logic [LW-1:0]         span;
	logic [CW-1:0]         cnt_m1;
	logic                  in_range;
	logic                  ins_ok;
	logic                  legal_d;
	logic [CW-1:0]         rem_d;
	logic [AW-1:0]         ra_d;
	logic [63:0]           in64;
	logic                  issue;
	logic                  finish;
	logic [AW-1:0]         pos_addr;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic [DATA_WIDTH-1:0] ram_rdata;
	logic [CW-1:0]         cnt_new;
	logic [CW+6:0]         len_x;
	logic [AW+5:0]         hpos_x;
	logic [63:0]           rdv64;
	ale_result_t           res_d;

	assign busy   = (state_q == ST_RUN);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = res_q;

	// Bound checks against the current length.
	assign cnt_ext  = LW'(cnt_q);
	assign pos_ext  = LW'(cmd.position);
	assign cap_ext  = LW'(CAPACITY);
	assign span     = cnt_ext - pos_ext;
	assign cnt_m1   = cnt_q - CW'(1);
	assign in_range = pos_ext < cnt_ext;
	assign ins_ok   = (cnt_ext < cap_ext) && (pos_ext <= cnt_ext);
	assign in64     = 64'(cmd.item_value);

	// Walk setup for each action: legality, entries to read and first read address.
	always_comb begin
		legal_d = 1'b0;
		rem_d   = '0;
		ra_d    = pos_ext[AW-1:0];
		case (cmd.action)
			ACT_READ: begin
				legal_d = in_range;
				rem_d   = in_range ? CW'(1) : '0;
			end
			ACT_WRITE: begin
				legal_d = in_range;
			end
			ACT_INSERT: begin
				legal_d = ins_ok;
				rem_d   = ins_ok ? span[CW-1:0] : '0;
				ra_d    = cnt_m1[AW-1:0];
			end
			ACT_REMOVE: begin
				legal_d = in_range;
				rem_d   = in_range ? span[CW-1:0] : '0;
			end
			ACT_SEARCH: begin
				legal_d = 1'b1;
				rem_d   = cnt_q;
				ra_d    = '0;
			end
			ACT_CLEAR: begin
				legal_d = 1'b1;
			end
			default: begin
				legal_d = 1'b0;
			end
		endcase
	end

	// The walk reads one entry a cycle; the read data returns in the next cycle.
	assign issue    = busy && (rem_q != '0);
	assign finish   = busy && (rem_q == '0) && !pend_q;
	assign pos_addr = pos_q[AW-1:0];

	// Write port: shifted entries during the walk, the new value at the end.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_addr;
		ram_wdata = val_q;
		if (pend_q) begin
			if (act_q == ACT_INSERT) begin
				ram_we    = 1'b1;
				ram_waddr = pa_q + AW'(1);
				ram_wdata = ram_rdata;
			end else if ((act_q == ACT_REMOVE) && (pa_q != pos_addr)) begin
				ram_we    = 1'b1;
				ram_waddr = pa_q - AW'(1);
				ram_wdata = ram_rdata;
			end
		end else if (finish && legal_q && ((act_q == ACT_INSERT) || (act_q == ACT_WRITE))) begin
			ram_we = 1'b1;
		end
	end

	ale_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (ra_q),
		.rdata (ram_rdata)
	);

	// Length after the action and the result transaction.
	always_comb begin
		cnt_new = cnt_q;
		if (legal_q) begin
			case (act_q)
				ACT_INSERT: cnt_new = cnt_q + CW'(1);
				ACT_REMOVE: cnt_new = cnt_q - CW'(1);
				ACT_CLEAR:  cnt_new = '0;
				default:    cnt_new = cnt_q;
			endcase
		end
	end

	assign len_x  = (CW + 7)'(cnt_new);
	assign hpos_x = (AW + 6)'(hpos_q);
	assign rdv64  = 64'(rdv_q);

	always_comb begin
		res_d              = '0;
		res_d.ok           = legal_q;
		res_d.read_value   = (legal_q && ((act_q == ACT_READ) || (act_q == ACT_REMOVE))) ?
		                     rdv64[31:0] : 32'd0;
		res_d.hit          = (act_q == ACT_SEARCH) && hit_q;
		res_d.hit_position = ((act_q == ACT_SEARCH) && hit_q) ? hpos_x[5:0] : 6'd0;
		res_d.list_length  = len_x[6:0];
		res_d.is_empty     = (cnt_new == '0);
		res_d.is_full      = (LW'(cnt_new) == cap_ext);
	end

	// Sequencer and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						rem_q   <= rem_d;
						pend_q  <= 1'b0;
						hit_q   <= 1'b0;
					end
				end
				ST_RUN: begin
					pend_q <= issue;
					if (issue) begin
						rem_q <= rem_q - CW'(1);
					end
					if (pend_q && (act_q == ACT_SEARCH) && !hit_q && (ram_rdata == val_q)) begin
						hit_q <= 1'b1;
					end
					if (finish) begin
						cnt_q   <= cnt_new;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command and walk data registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= cmd.action;
			pos_q   <= pos_ext;
			val_q   <= in64[DATA_WIDTH-1:0];
			legal_q <= legal_d;
			ra_q    <= ra_d;
		end else if (issue) begin
			ra_q <= (act_q == ACT_INSERT) ? ra_q - AW'(1) : ra_q + AW'(1);
		end
		if (issue) begin
			pa_q <= ra_q;
		end
		if (pend_q && (((act_q == ACT_REMOVE) && (pa_q == pos_addr)) || (act_q == ACT_READ))) begin
			rdv_q <= ram_rdata;
		end
		if (pend_q && (act_q == ACT_SEARCH) && !hit_q && (ram_rdata == val_q)) begin
			hpos_q <= pa_q;
		end
		if (finish) begin
			res_q <= res_d;
		end
	end

	// The length never exceeds the capacity.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(cnt_q) <= cap_ext)
		else $error("list length beyond capacity");

	// Every write lands inside the storage.
	a_waddr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (LW'(ram_waddr) < cap_ext))
		else $error("RAM write outside capacity");

	// A result strobe only ends a run of the sequencer.
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_RUN))
		else $error("result strobe without a command in flight");

	// An accepted command makes the engine busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted command did not start the sequencer");

	// No read is issued once the walk is finishing.
	a_no_read_at_finish: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> !issue)
		else $error("read issued while finishing");

endmodule

// ----- rtl/core/ale_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port with the data registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- dv/array_list_checker.sv -----
// Checker for the array list engine: watches the command and result channels,
// predicts each result from its own list model and compares field by field.
// Depends on ale_pkg for the transaction types and action codes.
module array_list_checker #(
	parameter int CAPACITY = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  ale_pkg::ale_cmd_t    cmd,
	input  logic                 done,
	input  ale_pkg::ale_result_t result,
	output int                   fail_count,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import ale_pkg::*;

	// Shadow copy of the list contents and its length.
	logic [31:0] list_store [CAPACITY];
	logic [6:0]  list_len;

	// Results predicted for accepted commands, oldest first.
	ale_result_t expected_results [$];

	// Applies one command to the shadow list and returns the result it yields.
	function automatic ale_result_t apply_list_action(ale_cmd_t c);
		ale_result_t r;
		int          i;
		logic        found;
		r     = '0;
		found = 1'b0;
		case (c.action)
			ACT_READ: begin
				if (c.position < list_len) begin
					r.ok         = 1'b1;
					r.read_value = list_store[c.position];
				end
			end
			ACT_WRITE: begin
				if (c.position < list_len) begin
					r.ok                  = 1'b1;
					list_store[c.position] = c.item_value;
				end
			end
			ACT_INSERT: begin
				if (list_len < CAPACITY && c.position <= list_len) begin
					for (i = int'(list_len); i > int'(c.position); i--)
						list_store[i] = list_store[i - 1];
					list_store[c.position] = c.item_value;
					list_len = list_len + 7'd1;
					r.ok     = 1'b1;
				end
			end
			ACT_REMOVE: begin
				if (c.position < list_len) begin
					r.read_value = list_store[c.position];
					for (i = int'(c.position); i + 1 < int'(list_len); i++)
						list_store[i] = list_store[i + 1];
					list_len = list_len - 7'd1;
					r.ok     = 1'b1;
				end
			end
			ACT_SEARCH: begin
				r.ok = 1'b1;
				for (i = 0; i < int'(list_len); i++) begin
					if (!found && list_store[i] == c.item_value) begin
						found          = 1'b1;
						r.hit          = 1'b1;
						r.hit_position = i[5:0];
					end
				end
			end
			ACT_CLEAR: begin
				list_len = '0;
				r.ok     = 1'b1;
			end
			default: begin
			end
		endcase
		r.list_length = list_len;
		r.is_empty    = (list_len == 0);
		r.is_full     = (list_len >= CAPACITY);
		return r;
	endfunction

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t ns: result mismatch in %s: got %h, expected %h", $time, field, got, want);
		fail_count++;
	endtask

	// Compares every field of an observed result with its prediction.
	task automatic compare_result(ale_result_t got, ale_result_t want);
		if (got.ok !== want.ok)
			report_mismatch("ok", 32'(got.ok), 32'(want.ok));
		if (got.read_value !== want.read_value)
			report_mismatch("read_value", got.read_value, want.read_value);
		if (got.hit !== want.hit)
			report_mismatch("hit", 32'(got.hit), 32'(want.hit));
		if (got.hit_position !== want.hit_position)
			report_mismatch("hit_position", 32'(got.hit_position), 32'(want.hit_position));
		if (got.list_length !== want.list_length)
			report_mismatch("list_length", 32'(got.list_length), 32'(want.list_length));
		if (got.is_empty !== want.is_empty)
			report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
		if (got.is_full !== want.is_full)
			report_mismatch("is_full", 32'(got.is_full), 32'(want.is_full));
	endtask

	initial fail_count = 0;

	// Result transactions are checked before the command of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len = '0;
			expected_results.delete();
			pending <= 0;
		end else begin
			if (done === 1'b1) begin
				if (expected_results.size() == 0)
					report_mismatch("result with no command waiting", 32'(result), '0);
				else
					compare_result(result, expected_results.pop_front());
			end
			if (start === 1'b1 && busy === 1'b0)
				expected_results.push_back(apply_list_action(cmd));
			pending <= expected_results.size();
		end
	end

endmodule

// ----- dv/tb_array_list_engine_top.sv -----
// Testbench top for the array list engine: clock, reset and command stimulus.
// Depends on ale_pkg, array_list_engine_top and array_list_checker.
module tb_array_list_engine_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ale_pkg::*;

	localparam int CAPACITY     = 64;
	localparam int RANDOM_ITEMS = 400;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 80;

	// Action codes the block must ignore.
	localparam logic [2:0] ACT_UNDEF_LO = 3'd6;
	localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

	typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED, MODE_NOISE} stim_mode_t;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        start  = 1'b0;
	ale_cmd_t    cmd    = '0;
	logic        busy;
	logic        done;
	ale_result_t result;
	int          fail_count;
	int          pending;
	int          cycle_count = 0;

	// Stimulus bookkeeping: list length as the commands leave it, and a pool of
	// values reused so that searches find duplicates and hits.
	int          stim_len = 0;
	int          items_sent = 0;
	logic        no_idle = 1'b0;
	logic [31:0] value_pool [8];

	array_list_engine_top #(
		.CAPACITY(CAPACITY),
		.DATA_WIDTH(32)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	array_list_checker #(
		.CAPACITY(CAPACITY)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.fail_count(fail_count),
		.pending(pending)
	);

	// Clock generation.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** array_list_engine_top: FAILED **");
			$finish;
		end
	end

	// Gap after a transaction: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (no_idle)
			return 0;
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return value_pool[$urandom_range(7)];
		if (r < 55)
			return 32'h0000_0000;
		if (r < 60)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	// Position mostly within 0..limit, sometimes anywhere.
	function automatic logic [5:0] pick_position(int limit);
		if ($urandom_range(99) < 15 || limit < 0)
			return 6'($urandom_range(63));
		return 6'($urandom_range(limit > 63 ? 63 : limit));
	endfunction

	// Drives one command and waits until it is accepted.
	task automatic send_item(logic [2:0] act, logic [5:0] pos, logic [31:0] val);
		int gap;
		start <= 1'b1;
		cmd   <= '{action: act, position: pos, item_value: val};
		do @(posedge clk); while (busy !== 1'b0);
		items_sent++;
		case (act)
			ACT_INSERT: begin
				if (stim_len < CAPACITY && pos <= stim_len)
					stim_len++;
			end
			ACT_REMOVE: begin
				if (pos < stim_len)
					stim_len--;
			end
			ACT_CLEAR: begin
				stim_len = 0;
			end
			default: begin
			end
		endcase
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// One random transaction shaped by the current mode.
	task automatic send_random(stim_mode_t mode);
		int         r;
		logic [2:0] act;
		r = $urandom_range(99);
		case (mode)
			MODE_GROW: begin
				act = (r < 60) ? ACT_INSERT : (r < 70) ? ACT_READ : (r < 80) ? ACT_WRITE :
					(r < 92) ? ACT_SEARCH : ACT_REMOVE;
			end
			MODE_SHRINK: begin
				act = (r < 55) ? ACT_REMOVE : (r < 65) ? ACT_INSERT : (r < 75) ? ACT_READ :
					(r < 87) ? ACT_SEARCH : (r < 97) ? ACT_WRITE : ACT_CLEAR;
			end
			MODE_MIXED: begin
				act = (r < 3) ? ACT_CLEAR : 3'($urandom_range(4));
			end
			default: begin
				send_item(3'($urandom_range(7)), 6'($urandom_range(63)), $urandom);
				return;
			end
		endcase
		if (act == ACT_INSERT)
			send_item(act, pick_position(stim_len), pick_value());
		else
			send_item(act, pick_position(stim_len - 1), pick_value());
	endtask

	// Stimulus and verdict.
	initial begin
		stim_mode_t mode;
		int         seg_len;
		for (int i = 0; i < 8; i++)
			value_pool[i] = $urandom;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: refusals on an empty list, inserts at front, end and middle,
		// bounds at the length, duplicate search, ignored codes and clear.
		send_item(ACT_READ, 6'd0, 32'h0);
		send_item(ACT_WRITE, 6'd0, 32'h1111_1111);
		send_item(ACT_REMOVE, 6'd0, 32'h0);
		send_item(ACT_INSERT, 6'd1, 32'h2222_2222);
		send_item(ACT_SEARCH, 6'd0, 32'h0);
		send_item(ACT_INSERT, 6'd0, 32'hFFFF_FFFF);
		send_item(ACT_INSERT, 6'd0, 32'h0000_0000);
		send_item(ACT_INSERT, 6'd2, 32'hA5A5_A5A5);
		send_item(ACT_INSERT, 6'd1, 32'h5A5A_5A5A);
		send_item(ACT_READ, 6'd3, 32'h0);
		send_item(ACT_READ, 6'd4, 32'h0);
		send_item(ACT_WRITE, 6'd3, 32'h1234_5678);
		send_item(ACT_SEARCH, 6'd0, 32'hFFFF_FFFF);
		send_item(ACT_SEARCH, 6'd63, 32'hDEAD_BEEF);
		send_item(ACT_INSERT, 6'd63, 32'h3333_3333);
		send_item(ACT_REMOVE, 6'd0, 32'h0);
		send_item(ACT_REMOVE, 6'd2, 32'h0);
		send_item(ACT_INSERT, 6'd1, 32'h0000_0000);
		send_item(ACT_SEARCH, 6'd0, 32'h0000_0000);
		send_item(ACT_UNDEF_LO, 6'd0, 32'h0);
		send_item(ACT_UNDEF_HI, 6'd63, 32'hFFFF_FFFF);
		send_item(ACT_CLEAR, 6'd0, 32'h0);
		send_item(ACT_READ, 6'd0, 32'h0);
		send_item(ACT_INSERT, 6'd0, 32'h0000_0001);

		// Fill the list to capacity, then work at the top position.
		items_sent = 0;
		while (stim_len < CAPACITY)
			send_item(ACT_INSERT, pick_position(stim_len), pick_value());
		send_item(ACT_INSERT, 6'($urandom_range(63)), pick_value());
		send_item(ACT_INSERT, 6'd0, pick_value());
		send_item(ACT_READ, 6'd63, 32'h0);
		send_item(ACT_WRITE, 6'd63, value_pool[0]);
		send_item(ACT_SEARCH, 6'd0, value_pool[0]);
		send_item(ACT_SEARCH, 6'd0, 32'hFFFF_FFFE);
		send_item(ACT_REMOVE, 6'd63, 32'h0);
		send_item(ACT_REMOVE, 6'd0, 32'h0);

		// Random segments, each with its own mode and idling style.
		while (items_sent < RANDOM_ITEMS) begin
			mode    = stim_mode_t'($urandom_range(3));
			seg_len = $urandom_range(50, 15);
			no_idle = ($urandom_range(3) == 0);
			repeat (seg_len) send_random(mode);
		end
		start <= 1'b0;

		// Drain: wait for every expected result, then for stray ones.
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("** array_list_engine_top: PASSED **");
		else
			$display("** array_list_engine_top: FAILED **");
		$finish;
	end

endmodule
